>>> hw/rtl/msr_pkg.sv
package msr_pkg;

  // Leg count and position format.
  localparam int LEGS      = 6;
  localparam int FRAC_BITS = 16;
  localparam int DIRS      = 4;

  // Field widths set by the interface.
  localparam int CMD_W   = 2;
  localparam int LEG_W   = 3;
  localparam int DIR_W   = 2;
  localparam int DEG_W   = 8;
  localparam int STEPS_W = 10;

  // Derived widths.
  localparam int POS_W      = DEG_W + FRAC_BITS;
  localparam int STEP_W     = POS_W + 1;
  localparam int LEG_IDX_W  = (LEGS > 1) ? $clog2(LEGS) : 1;
  localparam int TGT_IDX_W  = LEG_IDX_W + DIR_W;
  localparam int DIV_CNT_W  = $clog2(POS_W);

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_CALIB    = 2'd0,
    CMD_PLAN     = 2'd1,
    CMD_MOVE     = 2'd2,
    CMD_MOVE_ALL = 2'd3
  } cmd_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;
    logic calib;
    logic plan_start;
    logic step_we;
    logic move;
    logic move_all;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic all_last;
  } stat_t;

endpackage

>>> hw/rtl/msr_div.sv
module msr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [msr_pkg::POS_W-1:0]     dividend_i,
  input  logic [msr_pkg::STEPS_W-1:0]   divisor_i,
  input  logic                          neg_i,
  output logic                          done_o,
  output logic [msr_pkg::STEP_W-1:0]    quotient_o
);

  logic                            run_q, run_d;
  logic                            done_q, done_d;
  logic [msr_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [msr_pkg::POS_W-1:0]       quo_q, quo_d;
  logic [msr_pkg::STEPS_W-1:0]     rem_q, rem_d;
  logic [msr_pkg::STEPS_W-1:0]     dvs_q, dvs_d;
  logic                            neg_q, neg_d;
  logic [msr_pkg::STEPS_W:0]       rem_sh;
  logic [msr_pkg::STEPS_W:0]       rem_sub;
  logic [msr_pkg::STEP_W-1:0]      quo_ext;

  // One restoring step per cycle: shift in the next dividend bit and subtract.
  assign rem_sh  = {rem_q, quo_q[msr_pkg::POS_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      neg_d = neg_i;
    end else if (run_q) begin
      if (rem_sub[msr_pkg::STEPS_W]) begin
        rem_d = rem_sh[msr_pkg::STEPS_W-1:0];
        quo_d = {quo_q[msr_pkg::POS_W-2:0], 1'b0};
      end else begin
        rem_d = rem_sub[msr_pkg::STEPS_W-1:0];
        quo_d = {quo_q[msr_pkg::POS_W-2:0], 1'b1};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == msr_pkg::DIV_CNT_W'(msr_pkg::POS_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  // Quotient magnitude gets the sign back, truncated toward zero.
  assign quo_ext    = {1'b0, quo_q};
  assign quotient_o = neg_q ? (-quo_ext) : quo_ext;
  assign done_o     = done_q;

  // The done pulse lasts one cycle.
  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held longer than one cycle");

  // Done follows only the final step of a running division.
  a_done_after_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_d |-> run_q) else $error("divider done without a running division");

  // A division is not restarted while one is under way.
  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> !start_i) else $error("divider restarted while running");

endmodule

>>> hw/rtl/msr_dp.sv
module msr_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  msr_pkg::ctrl_t                ctrl_i,
  output msr_pkg::stat_t                stat_o,
  input  logic [msr_pkg::LEG_W-1:0]     leg_i,
  input  logic [msr_pkg::DIR_W-1:0]     direction_i,
  input  logic [msr_pkg::DEG_W-1:0]     degree_i,
  input  logic [msr_pkg::STEPS_W-1:0]   steps_i,
  output logic                          result_valid_o,
  output logic [msr_pkg::LEG_W-1:0]     out_leg_o,
  output logic                          axis_o,
  output logic [msr_pkg::DEG_W-1:0]     angle_o,
  output logic                          last_o
);

  // Latched input word.
  logic [msr_pkg::LEG_W-1:0]       leg_q;
  logic [msr_pkg::DIR_W-1:0]       dir_q;
  logic [msr_pkg::DEG_W-1:0]       deg_q;
  logic [msr_pkg::STEPS_W-1:0]     steps_q;

  // Servo state.
  logic [msr_pkg::DEG_W-1:0]       tgt_q  [msr_pkg::LEGS*msr_pkg::DIRS];
  logic [msr_pkg::POS_W-1:0]       vpos_q [msr_pkg::LEGS];
  logic [msr_pkg::POS_W-1:0]       hpos_q [msr_pkg::LEGS];
  logic [msr_pkg::STEP_W-1:0]      step_q [msr_pkg::LEGS];
  logic [msr_pkg::LEGS-1:0]        axis_q;
  logic [msr_pkg::LEG_IDX_W-1:0]   cnt_q;

  // Result register.
  logic                            valid_q;
  logic [msr_pkg::LEG_W-1:0]       out_leg_q;
  logic                            out_axis_q;
  logic [msr_pkg::DEG_W-1:0]       angle_q;
  logic                            last_q;

  logic [msr_pkg::LEG_IDX_W-1:0]   leg_idx;
  logic [msr_pkg::TGT_IDX_W-1:0]   tgt_idx;
  logic [msr_pkg::LEG_IDX_W-1:0]   rd_idx;
  logic                            rd_axis;
  logic [msr_pkg::POS_W-1:0]       rd_pos;
  logic [msr_pkg::STEP_W-1:0]      rd_step;
  logic [msr_pkg::POS_W+1:0]       sum;
  logic [msr_pkg::POS_W-1:0]       new_pos;
  logic [msr_pkg::STEP_W-1:0]      diff;
  logic [msr_pkg::STEP_W-1:0]      diff_abs;
  logic [msr_pkg::STEPS_W-1:0]     divisor;
  logic                            div_done;
  logic [msr_pkg::STEP_W-1:0]      quotient;
  logic                            all_last;
  logic                            emit;

  // Addressing: one leg per cycle, either the latched leg or the sweep counter.
  assign leg_idx = msr_pkg::LEG_IDX_W'(leg_q);
  assign tgt_idx = {leg_idx, dir_q};
  assign rd_idx  = ctrl_i.move_all ? cnt_q : leg_idx;
  assign rd_axis = ctrl_i.plan_start ? dir_q[1] : axis_q[rd_idx];
  assign rd_pos  = rd_axis ? hpos_q[rd_idx] : vpos_q[rd_idx];
  assign rd_step = step_q[rd_idx];

  // Move: add the signed step and saturate to the position range.
  assign sum = {2'b00, rd_pos} + {rd_step[msr_pkg::STEP_W-1], rd_step};
  always_comb begin
    if (sum[msr_pkg::POS_W+1]) begin
      new_pos = '0;
    end else if (sum[msr_pkg::POS_W]) begin
      new_pos = msr_pkg::POS_MAX;
    end else begin
      new_pos = sum[msr_pkg::POS_W-1:0];
    end
  end

  // Plan: exact difference to the target, divided as sign and magnitude.
  assign diff     = {1'b0, tgt_q[tgt_idx], msr_pkg::FRAC_BITS'(0)} - {1'b0, rd_pos};
  assign diff_abs = diff[msr_pkg::STEP_W-1] ? (-diff) : diff;
  assign divisor  = (steps_q == '0) ? msr_pkg::STEPS_W'(1) : steps_q;

  msr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.plan_start),
    .dividend_i (diff_abs[msr_pkg::POS_W-1:0]),
    .divisor_i  (divisor),
    .neg_i      (diff[msr_pkg::STEP_W-1]),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign all_last        = (cnt_q == msr_pkg::LEG_IDX_W'(msr_pkg::LEGS - 1));
  assign stat_o.div_done = div_done;
  assign stat_o.all_last = all_last;
  assign emit            = ctrl_i.calib | ctrl_i.move | ctrl_i.move_all;

  // Input word capture.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      leg_q   <= leg_i;
      dir_q   <= direction_i;
      deg_q   <= degree_i;
      steps_q <= steps_i;
    end
  end

  // Targets, positions, steps, chosen axis and the sweep counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < msr_pkg::LEGS * msr_pkg::DIRS; i++) begin
        tgt_q[i] <= '0;
      end
      for (int i = 0; i < msr_pkg::LEGS; i++) begin
        vpos_q[i] <= '0;
        hpos_q[i] <= '0;
        step_q[i] <= '0;
      end
      axis_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (ctrl_i.calib) begin
        tgt_q[tgt_idx] <= deg_q;
        if (dir_q[1]) begin
          hpos_q[leg_idx] <= {deg_q, msr_pkg::FRAC_BITS'(0)};
        end else begin
          vpos_q[leg_idx] <= {deg_q, msr_pkg::FRAC_BITS'(0)};
        end
      end
      if (ctrl_i.plan_start) begin
        axis_q[leg_idx] <= dir_q[1];
      end
      if (ctrl_i.step_we) begin
        step_q[leg_idx] <= quotient;
      end
      if (ctrl_i.move || ctrl_i.move_all) begin
        if (rd_axis) begin
          hpos_q[rd_idx] <= new_pos;
        end else begin
          vpos_q[rd_idx] <= new_pos;
        end
      end
      if (ctrl_i.cap) begin
        cnt_q <= '0;
      end else if (ctrl_i.move_all) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= emit;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.calib) begin
      out_leg_q  <= leg_q;
      out_axis_q <= dir_q[1];
      angle_q    <= deg_q;
      last_q     <= 1'b1;
    end else if (ctrl_i.move || ctrl_i.move_all) begin
      out_leg_q  <= ctrl_i.move_all ? msr_pkg::LEG_W'(cnt_q) : leg_q;
      out_axis_q <= rd_axis;
      angle_q    <= new_pos[msr_pkg::POS_W-1:msr_pkg::FRAC_BITS];
      last_q     <= ctrl_i.move_all ? all_last : 1'b1;
    end
  end

  assign result_valid_o = valid_q;
  assign out_leg_o      = out_leg_q;
  assign axis_o         = out_axis_q;
  assign angle_o        = angle_q;
  assign last_o         = last_q;

  // A result word is only registered from a calibrate, move or move-all command.
  a_valid_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(emit)) else $error("result strobe without a source");

  // Within a sweep, only the final leg carries last.
  a_sweep_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.move_all && !all_last) |=> (valid_q && !last_q))
    else $error("last set before the final leg of a sweep");

  // The step write comes only with the divider's done pulse.
  a_step_we : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.step_we |-> div_done) else $error("step written without a quotient");

endmodule

>>> hw/rtl/msr_ctrl.sv
module msr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [msr_pkg::CMD_W-1:0]     command_i,
  input  logic [msr_pkg::LEG_W-1:0]     leg_i,
  input  msr_pkg::stat_t                stat_i,
  output msr_pkg::ctrl_t                ctrl_o,
  output logic                          busy_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_CALIB    = 6'b000010,
    S_PLAN     = 6'b000100,
    S_DIV      = 6'b001000,
    S_MOVE     = 6'b010000,
    S_MOVE_ALL = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  logic   leg_ok;

  assign accept = start_i && (state_q == S_IDLE);
  assign leg_ok = (int'(leg_i) < msr_pkg::LEGS);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (msr_pkg::cmd_e'(command_i))
            msr_pkg::CMD_CALIB:    state_d = leg_ok ? S_CALIB : S_IDLE;
            msr_pkg::CMD_PLAN:     state_d = leg_ok ? S_PLAN : S_IDLE;
            msr_pkg::CMD_MOVE:     state_d = leg_ok ? S_MOVE : S_IDLE;
            msr_pkg::CMD_MOVE_ALL: state_d = S_MOVE_ALL;
            default:               state_d = S_IDLE;
          endcase
        end
      end
      S_CALIB:    state_d = S_IDLE;
      S_PLAN:     state_d = S_DIV;
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_IDLE;
        end
      end
      S_MOVE:     state_d = S_IDLE;
      S_MOVE_ALL: begin
        if (stat_i.all_last) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath commands.
  assign ctrl_o.cap        = accept;
  assign ctrl_o.calib      = (state_q == S_CALIB);
  assign ctrl_o.plan_start = (state_q == S_PLAN);
  assign ctrl_o.step_we    = (state_q == S_DIV) && stat_i.div_done;
  assign ctrl_o.move       = (state_q == S_MOVE);
  assign ctrl_o.move_all   = (state_q == S_MOVE_ALL);
  assign busy_o            = (state_q != S_IDLE);

  // A plan waits for the divider.
  a_div_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !stat_i.div_done) |=> (state_q == S_DIV))
    else $error("plan left before the quotient was ready");

  // A sweep covers every leg before going idle.
  a_sweep_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE_ALL && !stat_i.all_last) |=> (state_q == S_MOVE_ALL))
    else $error("sweep ended before the final leg");

  // Every plan start leads into the divider wait.
  a_plan_to_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLAN) |=> (state_q == S_DIV))
    else $error("plan start not followed by divider wait");

endmodule

>>> hw/rtl/multi_servo_linear_ramp.sv
// Channel   Direction  Ports                                             Handshake
// command   in         command_i leg_i direction_i degree_i steps_i      start_i & !busy_o
// result    out        out_leg_o axis_o angle_o last_o                   result_valid_o
//
// Calibrate and move-one act in the cycle after the accepted word; the result word
// then comes from the output register.
// Plan holds busy_o through a load step, 24 divider steps (one per position bit)
// and a write-back step; it returns no result. The receiver cannot stall.
// Move-all steps every leg in turn, one result word each, last on the final leg.
// Reset is asynchronous, active low, and clears control and servo state.
module multi_servo_linear_ramp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [msr_pkg::CMD_W-1:0]     command_i,
  input  logic [msr_pkg::LEG_W-1:0]     leg_i,
  input  logic [msr_pkg::DIR_W-1:0]     direction_i,
  input  logic [msr_pkg::DEG_W-1:0]     degree_i,
  input  logic [msr_pkg::STEPS_W-1:0]   steps_i,
  output logic                          result_valid_o,
  output logic [msr_pkg::LEG_W-1:0]     out_leg_o,
  output logic                          axis_o,
  output logic [msr_pkg::DEG_W-1:0]     angle_o,
  output logic                          last_o
);

  msr_pkg::ctrl_t ctrl;
  msr_pkg::stat_t stat;

  // Sequencer.
  msr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .leg_i     (leg_i),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .busy_o    (busy_o)
  );

  // Servo state, divider and result register.
  msr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .leg_i          (leg_i),
    .direction_i    (direction_i),
    .degree_i       (degree_i),
    .steps_i        (steps_i),
    .result_valid_o (result_valid_o),
    .out_leg_o      (out_leg_o),
    .axis_o         (axis_o),
    .angle_o        (angle_o),
    .last_o         (last_o)
  );

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import msr_pkg::*;

  localparam int GAP_MAX     = 9;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_WORDS = 90;

  // One servo write as it appears on the result ports.
  typedef struct packed {
    logic [LEG_W-1:0] leg;
    logic             axis;
    logic [DEG_W-1:0] angle;
    logic             last;
  } servo_write_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [CMD_W-1:0]    command_i;
  logic [LEG_W-1:0]    leg_i;
  logic [DIR_W-1:0]    direction_i;
  logic [DEG_W-1:0]    degree_i;
  logic [STEPS_W-1:0]  steps_i;
  logic                result_valid_o;
  logic [LEG_W-1:0]    out_leg_o;
  logic                axis_o;
  logic [DEG_W-1:0]    angle_o;
  logic                last_o;

  // Shadow of the block state used to predict servo writes.
  logic [DEG_W-1:0]         target_deg [LEGS*DIRS];
  logic [POS_W-1:0]         vert_pos   [LEGS];
  logic [POS_W-1:0]         horiz_pos  [LEGS];
  logic signed [STEP_W-1:0] ramp_step  [LEGS];
  logic                     ramp_axis  [LEGS];

  servo_write_t servo_writes_due[$];

  int  failures;
  int  writes_checked;
  int  words_applied;
  int  words_by_cmd [4];
  int  hits_top;
  int  hits_floor;
  bit  steady_sender;
  int  stall_cycles;

  multi_servo_linear_ramp u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .leg_i          (leg_i),
    .direction_i    (direction_i),
    .degree_i       (degree_i),
    .steps_i        (steps_i),
    .result_valid_o (result_valid_o),
    .out_leg_o      (out_leg_o),
    .axis_o         (axis_o),
    .angle_o        (angle_o),
    .last_o         (last_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Steps one leg along its active axis with saturation and returns the new position.
  function automatic logic [POS_W-1:0] advance_leg(int idx);
    longint sum;
    if (ramp_axis[idx]) begin
      sum = longint'(horiz_pos[idx]);
    end else begin
      sum = longint'(vert_pos[idx]);
    end
    sum = sum + longint'(ramp_step[idx]);
    if (sum < 0) begin
      sum = 0;
      hits_floor++;
    end
    if (sum > longint'(POS_MAX)) begin
      sum = longint'(POS_MAX);
      hits_top++;
    end
    if (ramp_axis[idx]) begin
      horiz_pos[idx] = POS_W'(sum);
    end else begin
      vert_pos[idx] = POS_W'(sum);
    end
    return POS_W'(sum);
  endfunction

  function automatic void queue_write(int idx, logic ax, logic [POS_W-1:0] pos, logic lst);
    servo_write_t w;
    w.leg   = LEG_W'(idx);
    w.axis  = ax;
    w.angle = pos[POS_W-1:FRAC_BITS];
    w.last  = lst;
    servo_writes_due.push_back(w);
  endfunction

  // Updates the shadow state for one accepted command word and queues its servo writes.
  function automatic void apply_servo_command(cmd_e cmd, logic [LEG_W-1:0] leg,
                                              logic [DIR_W-1:0] dir,
                                              logic [DEG_W-1:0] deg,
                                              logic [STEPS_W-1:0] steps);
    int             li;
    logic           ax;
    logic [POS_W-1:0] pos;
    longint         diff;
    longint         cnt;
    li = int'(leg);
    ax = dir[1];
    words_by_cmd[cmd]++;
    if (cmd == CMD_MOVE_ALL) begin
      words_applied++;
      for (int i = 0; i < LEGS; i++) begin
        pos = advance_leg(i);
        queue_write(i, ramp_axis[i], pos, i == LEGS - 1);
      end
      return;
    end
    // Legs past the end are ignored by every per-leg command.
    if (li >= LEGS) begin
      return;
    end
    words_applied++;
    case (cmd)
      CMD_CALIB: begin
        target_deg[li*DIRS + int'(dir)] = deg;
        pos = {deg, {FRAC_BITS{1'b0}}};
        if (ax) begin
          horiz_pos[li] = pos;
        end else begin
          vert_pos[li] = pos;
        end
        queue_write(li, ax, pos, 1'b1);
      end
      CMD_PLAN: begin
        cnt = (steps == '0) ? 1 : longint'(steps);
        ramp_axis[li] = ax;
        pos = ax ? horiz_pos[li] : vert_pos[li];
        diff = (longint'(target_deg[li*DIRS + int'(dir)]) <<< FRAC_BITS) - longint'(pos);
        // Signed division truncates toward zero.
        ramp_step[li] = STEP_W'(diff / cnt);
      end
      default: begin
        pos = advance_leg(li);
        queue_write(li, ramp_axis[li], pos, 1'b1);
      end
    endcase
  endfunction

  task automatic note_failure(string msg);
    failures++;
    if (failures <= 10) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Sends one command word after a random gap (none when steady) and predicts its writes once busy_o clears.
  task automatic send_word(cmd_e cmd, int leg, int dir, int deg, int steps);
    int gap;
    gap = steady_sender ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i     <= 1'b1;
    command_i   <= cmd;
    leg_i       <= LEG_W'(leg);
    direction_i <= DIR_W'(dir);
    degree_i    <= DEG_W'(deg);
    steps_i     <= STEPS_W'(steps);
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    apply_servo_command(cmd, LEG_W'(leg), DIR_W'(dir), DEG_W'(deg), STEPS_W'(steps));
  endtask

  // Holds the sender off until every predicted write has arrived and a plan has settled.
  task automatic drain_writes();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (servo_writes_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Moves before any plan use the zero step on the vertical axis.
  task automatic test_reset_defaults();
    send_word(CMD_MOVE, 2, 0, 0, 0);
    send_word(CMD_MOVE_ALL, 0, 0, 0, 0);
  endtask

  // Calibration at the ends of the angle range, plus legs beyond the last one.
  task automatic test_calibrate_extremes();
    send_word(CMD_CALIB, 0, 0, 255, 0);
    send_word(CMD_CALIB, 5, 1, 0, 1023);
    send_word(CMD_CALIB, 3, 2, 128, 0);
    send_word(CMD_CALIB, 1, 3, 255, 0);
    send_word(CMD_CALIB, 4, 0, 1, 0);
    send_word(CMD_CALIB, 6, 1, 77, 0);
    send_word(CMD_CALIB, 7, 3, 200, 0);
  endtask

  // Plans with a zero and a full step count, moves on planned and stray legs, and a sweep.
  task automatic test_ramp_saturation();
    send_word(CMD_PLAN, 0, 1, 0, 0);
    send_word(CMD_MOVE, 0, 0, 0, 0);
    send_word(CMD_MOVE, 0, 0, 0, 0);
    send_word(CMD_PLAN, 3, 3, 0, 1023);
    send_word(CMD_MOVE, 3, 0, 0, 0);
    send_word(CMD_CALIB, 2, 0, 250, 0);
    send_word(CMD_CALIB, 2, 1, 10, 0);
    send_word(CMD_PLAN, 2, 0, 0, 1);
    send_word(CMD_MOVE, 2, 0, 0, 0);
    send_word(CMD_MOVE, 2, 0, 0, 0);
    send_word(CMD_PLAN, 6, 2, 0, 5);
    send_word(CMD_MOVE, 7, 0, 0, 0);
    send_word(CMD_MOVE_ALL, 0, 0, 0, 0);
  endtask

  // Mostly plan-then-move ramps with random content, mixed with stray words.
  task automatic test_random_ramps();
    int base;
    int iter;
    int leg;
    int steps;
    int n;
    base = words_applied;
    iter = 0;
    while (words_applied - base < RANDOM_WORDS) begin
      if (iter % 15 == 0) begin
        steady_sender = ($urandom_range(0, 3) == 0);
      end
      iter++;
      case ($urandom_range(0, 9))
        0, 1: begin
          send_word(CMD_CALIB, $urandom_range(0, 7), $urandom_range(0, 3),
                    $urandom_range(0, 255), $urandom_range(0, 1023));
        end
        2, 3, 4: begin
          leg   = $urandom_range(0, LEGS - 1);
          steps = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(0, 8);
          send_word(CMD_PLAN, leg, $urandom_range(0, 3), $urandom_range(0, 255), steps);
          n = $urandom_range(1, 8);
          repeat (n) begin
            send_word(CMD_MOVE, leg, $urandom_range(0, 3), $urandom_range(0, 255),
                      $urandom_range(0, 1023));
          end
        end
        5, 6: begin
          send_word(CMD_MOVE, $urandom_range(0, 7), $urandom_range(0, 3),
                    $urandom_range(0, 255), $urandom_range(0, 1023));
        end
        7: begin
          send_word(CMD_MOVE_ALL, $urandom_range(0, 7), $urandom_range(0, 3),
                    $urandom_range(0, 255), $urandom_range(0, 1023));
        end
        default: begin
          send_word(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 7),
                    $urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 1023));
        end
      endcase
    end
    steady_sender = 1'b0;
  endtask

  // Compares every result word with the oldest predicted write.
  always @(posedge clk_i) begin
    servo_write_t got;
    servo_write_t want;
    if (rst_ni && result_valid_o) begin
      got = '{leg: out_leg_o, axis: axis_o, angle: angle_o, last: last_o};
      if (servo_writes_due.size() == 0) begin
        note_failure($sformatf("unexpected write leg=%0d axis=%0d angle=%0d last=%0d",
                               got.leg, got.axis, got.angle, got.last));
      end else begin
        want = servo_writes_due.pop_front();
        writes_checked++;
        if (got.leg !== want.leg || got.axis !== want.axis ||
            got.angle !== want.angle || got.last !== want.last) begin
          note_failure($sformatf({"expected leg=%0d axis=%0d angle=%0d last=%0d, ",
                                  "got leg=%0d axis=%0d angle=%0d last=%0d"},
                                 want.leg, want.axis, want.angle, want.last,
                                 got.leg, got.axis, got.angle, got.last));
        end
      end
    end
  end

  // Ends the run if neither a command word nor a result word moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word accepted for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    command_i     = CMD_CALIB;
    leg_i         = '0;
    direction_i   = '0;
    degree_i      = '0;
    steps_i       = '0;
    failures      = 0;
    writes_checked = 0;
    words_applied = 0;
    hits_top      = 0;
    hits_floor    = 0;
    steady_sender = 1'b0;
    words_by_cmd  = '{default: 0};
    for (int i = 0; i < LEGS*DIRS; i++) target_deg[i] = '0;
    for (int i = 0; i < LEGS; i++) begin
      vert_pos[i]  = '0;
      horiz_pos[i] = '0;
      ramp_step[i] = '0;
      ramp_axis[i] = 1'b0;
    end

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_calibrate_extremes();
    test_ramp_saturation();
    drain_writes();
    test_random_ramps();
    drain_writes();

    // Anything still predicted at this point never arrived.
    if (servo_writes_due.size() != 0) begin
      note_failure($sformatf("%0d predicted writes never arrived", servo_writes_due.size()));
    end

    $display("Words: %0d calibrate, %0d plan, %0d move, %0d move-all; %0d writes checked",
             words_by_cmd[CMD_CALIB], words_by_cmd[CMD_PLAN], words_by_cmd[CMD_MOVE],
             words_by_cmd[CMD_MOVE_ALL], writes_checked);
    $display("Positions clamped at the top %0d times and at zero %0d times; %0d failures",
             hits_top, hits_floor, failures);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> multi_servo_linear_ramp.f
hw/rtl/msr_pkg.sv
hw/rtl/msr_div.sv
hw/rtl/msr_dp.sv
hw/rtl/msr_ctrl.sv
hw/rtl/multi_servo_linear_ramp.sv
test/testbench.sv
